### design/vdoh_pkg.sv
package vdoh_pkg;

   // varint code byte layout
   localparam int unsigned DATA_BITS = 7;
   localparam int unsigned MORE_BIT  = 7;
   localparam logic [6:0]  DATA_MASK = 7'h7F;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // command queue between decode front and count back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_COUNT,
      CMD_READ
   } cmd_kind_type;

   // value holds the absolute ordinal for a count, the index for a read
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  value;
      logic         oor;
   } queue_entry_type;

endpackage

### design/vdoh_req_if.sv
interface vdoh_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        doc_start;
   logic [7:0]  code_byte;
   logic [11:0] read_index;

   modport source (output valid, op, doc_start, code_byte, read_index, input ready);
   modport sink   (input valid, op, doc_start, code_byte, read_index, output ready);
endinterface

### design/vdoh_rsp_if.sv
interface vdoh_rsp_if;
   logic        valid;
   logic        ready;
   logic        ord_done;
   logic [31:0] ordinal;
   logic [31:0] count;
   logic        out_of_range;

   modport source (output valid, ord_done, ordinal, count, out_of_range, input ready);
   modport sink   (input valid, ord_done, ordinal, count, out_of_range, output ready);
endinterface

### design/varint_delta_ordinal_histogram_unit.sv
// varint delta ordinal histogram unit
// req_chan takes one item per handshake: a decode item carries one byte of a
//   big-endian 7-bit varint stream (bit 7 set = more bytes follow), doc_start
//   clears the partial value and the previous ordinal; a read item returns the
//   stored count for read_index
// rsp_chan gives exactly one item per request, in request order: ord_done with
//   the absolute ordinal, the count after the saturating increment or the count
//   read, and out_of_range for ordinals or indexes at or above NUM_ORDS
// throughput: one item per cycle sustained while rsp_chan is not stalled; the
//   count store is read on pop and written as the item leaves execute, the last
//   write is forwarded so back-to-back hits on one ordinal still count correctly
// path: a request passes through the command queue, the execute stage and the
//   response register before it shows on rsp_chan
// reset: after reset the count store is swept to zero, one entry per cycle, over
//   all NUM_ORDS entries; req_chan.ready stays low until the sweep is done
// stall: when rsp_chan.ready is low a held response stays put, the back end
//   stops, and the 4-entry command queue keeps taking requests until it fills
module varint_delta_ordinal_histogram_unit #(
   parameter int NUM_ORDS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   vdoh_req_if.sink   req_chan,
   vdoh_rsp_if.source rsp_chan
);

   logic                      push, pop;
   logic                      queue_not_full, queue_not_empty;
   logic                      init_done;
   vdoh_pkg::queue_entry_type push_entry, queue_head;

   // front: varint decode and delta add, classifies each item
   vdoh_front #(
      .NUM_ORDS (NUM_ORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .queue_not_full (queue_not_full),
      .init_done      (init_done),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decouples decode from the count store pipeline
   vdoh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_full   (queue_not_full),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // back: count store read-modify-write and response register
   vdoh_back #(
      .NUM_ORDS (NUM_ORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .init_done       (init_done),
      .rsp_chan        (rsp_chan)
   );

endmodule

### design/vdoh_ram.sv
module vdoh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old data on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/vdoh_front.sv
module vdoh_front #(
   parameter int NUM_ORDS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   vdoh_req_if.sink                  req_chan,
   input  logic                      queue_not_full,
   input  logic                      init_done,
   output logic                      push,
   output vdoh_pkg::queue_entry_type push_entry
);

   localparam logic [31:0] ORD_LIMIT = 32'(NUM_ORDS);

   logic [31:0] partial_ff, partial_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] base_part, base_prev, shifted, ord_sum, index_ext;

   assign req_chan.ready = queue_not_full & init_done;
   assign push           = req_chan.valid & req_chan.ready;

   always_comb begin
      base_part  = req_chan.doc_start ? 32'd0 : partial_ff;
      base_prev  = req_chan.doc_start ? 32'd0 : prev_ff;
      shifted    = base_part << vdoh_pkg::DATA_BITS;
      ord_sum    = (shifted | {24'd0, req_chan.code_byte}) + base_prev;
      index_ext  = {20'd0, req_chan.read_index};
      partial_in = partial_ff;
      prev_in    = prev_ff;
      push_entry = '{kind: vdoh_pkg::CMD_NONE, value: 32'd0, oor: 1'b0};
      if (req_chan.op) begin
         push_entry = '{kind: vdoh_pkg::CMD_READ, value: index_ext,
                        oor: (index_ext >= ORD_LIMIT)};
      end else if (req_chan.code_byte[vdoh_pkg::MORE_BIT]) begin
         // continuation byte extends the partial value
         partial_in = shifted | {25'd0, req_chan.code_byte[6:0] & vdoh_pkg::DATA_MASK};
         prev_in    = base_prev;
      end else begin
         // last byte: delta added to previous ordinal
         partial_in = 32'd0;
         prev_in    = ord_sum;
         push_entry = '{kind: vdoh_pkg::CMD_COUNT, value: ord_sum,
                        oor: (ord_sum >= ORD_LIMIT)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 32'd0;
         prev_ff    <= 32'd0;
      end else if (push) begin
         partial_ff <= partial_in;
         prev_ff    <= prev_in;
      end
   end

endmodule

### design/vdoh_queue.sv
module vdoh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vdoh_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output logic                      not_full,
   output logic                      not_empty,
   output vdoh_pkg::queue_entry_type head
);

   localparam logic [vdoh_pkg::QUEUE_PTR_W:0] FULL_COUNT =
      (vdoh_pkg::QUEUE_PTR_W + 1)'(vdoh_pkg::QUEUE_DEPTH);

   vdoh_pkg::queue_entry_type entry_ff [vdoh_pkg::QUEUE_DEPTH];
   logic [vdoh_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vdoh_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vdoh_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign not_full  = (count_ff != FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/vdoh_back.sv
module vdoh_back #(
   parameter int NUM_ORDS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_not_empty,
   input  vdoh_pkg::queue_entry_type queue_head,
   output logic                      pop,
   output logic                      init_done,
   vdoh_rsp_if.source                rsp_chan
);

   localparam int AW = $clog2(NUM_ORDS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ORDS - 1);

   // clearing sweep
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_done_ff, clr_done_in;

   // execute stage
   logic                      b_valid_ff, b_valid_in;
   vdoh_pkg::queue_entry_type b_entry_ff;
   logic [AW-1:0]             b_addr;
   logic                      b_adv, b_write, out_free;

   // last count written, for read-after-write forwarding
   logic          lw_valid_ff;
   logic [AW-1:0] lw_addr_ff;
   logic [31:0]   lw_data_ff;

   logic [31:0] ram_rdata, cur_count, inc_count;
   logic        ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0] ram_wdata;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        ord_done_ff, ord_done_in;
   logic [31:0] ordinal_ff, ordinal_in;
   logic [31:0] count_ff, count_in;
   logic        oor_ff, oor_in;

   assign init_done = clr_done_ff;
   assign out_free  = !rsp_valid_ff | rsp_chan.ready;
   assign b_adv     = b_valid_ff & out_free;
   assign pop       = queue_not_empty & clr_done_ff & (!b_valid_ff | b_adv);
   assign b_addr    = b_entry_ff.value[AW-1:0];
   assign b_write   = b_adv & (b_entry_ff.kind == vdoh_pkg::CMD_COUNT) & !b_entry_ff.oor;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         clr_done_in = (clr_addr_ff == LAST_ADDR);
      end
   end

   always_comb begin
      ram_we    = !clr_done_ff | b_write;
      ram_waddr = clr_done_ff ? b_addr : clr_addr_ff;
      ram_wdata = clr_done_ff ? inc_count : 32'd0;
   end

   vdoh_ram #(
      .WIDTH (32),
      .DEPTH (NUM_ORDS)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (pop),
      .raddr (queue_head.value[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      cur_count = (lw_valid_ff && lw_addr_ff == b_addr) ? lw_data_ff : ram_rdata;
      inc_count = (cur_count == vdoh_pkg::COUNT_MAX) ? cur_count : cur_count + 32'd1;
   end

   always_comb begin
      ord_done_in = 1'b0;
      ordinal_in  = 32'd0;
      count_in    = 32'd0;
      oor_in      = 1'b0;
      case (b_entry_ff.kind)
         vdoh_pkg::CMD_COUNT: begin
            ord_done_in = 1'b1;
            ordinal_in  = b_entry_ff.value;
            count_in    = b_entry_ff.oor ? 32'd0 : inc_count;
            oor_in      = b_entry_ff.oor;
         end
         vdoh_pkg::CMD_READ: begin
            count_in = b_entry_ff.oor ? 32'd0 : cur_count;
            oor_in   = b_entry_ff.oor;
         end
         default: begin
            ord_done_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         clr_done_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         clr_done_ff  <= clr_done_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_write) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_entry_ff <= queue_head;
      end
      if (b_write) begin
         lw_addr_ff <= b_addr;
         lw_data_ff <= inc_count;
      end
      if (b_adv) begin
         ord_done_ff <= ord_done_in;
         ordinal_ff  <= ordinal_in;
         count_ff    <= count_in;
         oor_ff      <= oor_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ord_done     = ord_done_ff;
   assign rsp_chan.ordinal      = ordinal_ff;
   assign rsp_chan.count        = count_ff;
   assign rsp_chan.out_of_range = oor_ff;

endmodule

### design/vdoh_checker.sv
module vdoh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ord_done,
   input logic [31:0] rsp_ordinal,
   input logic [31:0] rsp_count,
   input logic        rsp_out_of_range
);

   // response held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_ordinal) && $stable(rsp_count)
         && $stable(rsp_ord_done) && $stable(rsp_out_of_range))
      else $error("response payload changed while stalled");

   // clearing sweep blocks requests right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken before count store cleared");

   // a counted ordinal always has a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ord_done && !rsp_out_of_range |-> rsp_count != 32'd0)
      else $error("counted ordinal with zero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ord_done |-> rsp_ordinal == 32'd0)
      else $error("ordinal nonzero without ord_done");

endmodule

bind varint_delta_ordinal_histogram_unit vdoh_checker u_vdoh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_ord_done     (rsp_chan.ord_done),
   .rsp_ordinal      (rsp_chan.ordinal),
   .rsp_count        (rsp_chan.count),
   .rsp_out_of_range (rsp_chan.out_of_range)
);

### dv/tb_varint_delta_ordinal_histogram_unit.sv
module tb_varint_delta_ordinal_histogram_unit;

   // count store size, the block's default
   localparam int ORD_SLOTS = 4096;

   // request operation codes
   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned DRAIN_POINT  = 220;
   localparam int unsigned TAIL_CYCLES  = 8;

   // one result item as the block reports it
   typedef struct packed {
      logic        ord_done;
      logic [31:0] ordinal;
      logic [31:0] count;
      logic        out_of_range;
   } tally_type;

   // one directed item; typed rows carry their result, the rest use the predictor
   typedef struct packed {
      logic        op;
      logic        doc_start;
      logic [7:0]  code_byte;
      logic [11:0] read_index;
      logic        typed;
      tally_type   tally;
   } stim_row_type;

   logic clock;
   logic reset;

   vdoh_req_if req_chan ();
   vdoh_rsp_if rsp_chan ();

   varint_delta_ordinal_histogram_unit #(
      .NUM_ORDS (ORD_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: partial varint, previous ordinal of the document, hit counts
   bit [31:0] acc_value;
   bit [31:0] prev_ord;
   bit [31:0] ord_hits [ORD_SLOTS];

   tally_type pending_tallies [$];
   int unsigned fail_count;
   int unsigned sent_items;
   bit calm_stretch;

   // typed expectation travels with the item, driven like the payload
   logic      row_typed;
   tally_type row_tally;

   // directed part: extremes, both operations, continuation, range edge,
   // long codes that wrap, doc_start in the middle of a code, repeated hits;
   // count saturation needs 2^32 hits on one ordinal and is out of reach
   stim_row_type dir_rows [26] = '{
      // reads right after the sweep see zero
      '{OP_READ,   1'b0, 8'h00, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_READ,   1'b0, 8'h00, 12'd4095, 1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      // single-byte codes, delta zero twice on ordinal zero
      '{OP_DECODE, 1'b1, 8'h00, 12'd0,    1'b1, '{1'b1, 32'd0,    32'd1, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h00, 12'd0,    1'b1, '{1'b1, 32'd0,    32'd2, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h7F, 12'd0,    1'b1, '{1'b1, 32'd127,  32'd1, 1'b0}},
      // continuation bytes give an empty item
      '{OP_DECODE, 1'b0, 8'h80, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h81, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h00, 12'd0,    1'b0, '0},
      // read ignores doc_start and the code byte
      '{OP_READ,   1'b1, 8'hFF, 12'd0,    1'b0, '0},
      // last slot of the store, read_index ignored on decode
      '{OP_DECODE, 1'b1, 8'h9F, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h7F, 12'hFFF,  1'b1, '{1'b1, 32'd4095, 32'd1, 1'b0}},
      // first ordinal past the store
      '{OP_DECODE, 1'b1, 8'hA0, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_DECODE, 1'b0, 8'h00, 12'd0,    1'b1, '{1'b1, 32'd4096, 32'd0, 1'b1}},
      '{OP_DECODE, 1'b0, 8'h01, 12'd0,    1'b0, '0},
      // six-byte code, high bits shifted out
      '{OP_DECODE, 1'b1, 8'hFF, 12'd0,    1'b1, '{1'b0, 32'd0,    32'd0, 1'b0}},
      '{OP_DECODE, 1'b0, 8'hFF, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b0, 8'hFF, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b0, 8'hFF, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b0, 8'hFF, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b0, 8'h7F, 12'd0,    1'b0, '0},
      // doc_start drops a half-built code
      '{OP_DECODE, 1'b1, 8'h85, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b1, 8'h03, 12'd0,    1'b0, '0},
      // back-to-back hits on one ordinal
      '{OP_DECODE, 1'b0, 8'h00, 12'd0,    1'b0, '0},
      '{OP_DECODE, 1'b0, 8'h00, 12'd0,    1'b0, '0},
      '{OP_READ,   1'b0, 8'h00, 12'd3,    1'b0, '0},
      '{OP_READ,   1'b0, 8'h00, 12'd4095, 1'b0, '0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #6000000;
      $display("** varint_delta_ordinal_histogram_unit: FAILED **");
      $finish;
   end

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm_stretch || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // expected result of one accepted item, advances the predictor state
   function automatic tally_type predict_tally(input logic op, input logic doc_start,
                                               input logic [7:0] code_byte,
                                               input logic [11:0] read_index);
      tally_type   t;
      logic [31:0] ord;
      logic [31:0] hits;
      t = '0;
      if (op == OP_READ) begin
         if (read_index < ORD_SLOTS) t.count = ord_hits[read_index];
         else t.out_of_range = 1'b1;
         return t;
      end
      if (doc_start) begin
         acc_value = '0;
         prev_ord  = '0;
      end
      // continuation: shift in seven bits, nothing counted
      if (code_byte[vdoh_pkg::MORE_BIT]) begin
         acc_value = (acc_value << vdoh_pkg::DATA_BITS)
                   | {25'd0, code_byte[6:0] & vdoh_pkg::DATA_MASK};
         return t;
      end
      // last byte: delta plus previous ordinal, wraps at 32 bits
      ord = ((acc_value << vdoh_pkg::DATA_BITS) | {24'd0, code_byte}) + prev_ord;
      prev_ord  = ord;
      acc_value = '0;
      t.ord_done = 1'b1;
      t.ordinal  = ord;
      if (ord < ORD_SLOTS) begin
         hits = ord_hits[ord[11:0]];
         if (hits != vdoh_pkg::COUNT_MAX) hits = hits + 1;
         ord_hits[ord[11:0]] = hits;
         t.count = hits;
      end else begin
         t.out_of_range = 1'b1;
      end
      return t;
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic op, input logic doc_start, input logic [7:0] code_byte,
                            input logic [11:0] read_index, input logic typed,
                            input tally_type tally);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.doc_start  <= doc_start;
      req_chan.code_byte  <= code_byte;
      req_chan.read_index <= read_index;
      row_typed           <= typed;
      row_tally           <= tally;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   // result side: ready high for a run, then an optional stall
   initial begin
      int unsigned stall;
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // check results in order, then record what each accepted request should give
   always @(posedge clock) begin
      tally_type got;
      tally_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.ord_done, rsp_chan.ordinal, rsp_chan.count,
                    rsp_chan.out_of_range};
            if (pending_tallies.size() == 0) begin
               $error("result item with none expected: ordinal %0d count %0d",
                      got.ordinal, got.count);
               fail_count++;
            end else begin
               want = pending_tallies.pop_front();
               if (got.ord_done !== want.ord_done) begin
                  $error("ord_done: expected %0d, got %0d", want.ord_done, got.ord_done);
                  fail_count++;
               end
               if (got.ordinal !== want.ordinal) begin
                  $error("ordinal: expected %0d, got %0d", want.ordinal, got.ordinal);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, got.count);
                  fail_count++;
               end
               if (got.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d",
                         want.out_of_range, got.out_of_range);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            // predictor always runs so its state follows the block
            want = predict_tally(req_chan.op, req_chan.doc_start, req_chan.code_byte,
                                 req_chan.read_index);
            if (row_typed) want = row_tally;
            pending_tallies.push_back(want);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned group;
      int unsigned n_ords;
      int unsigned n_grp;
      int unsigned n_bytes;
      int unsigned pick;
      logic [31:0] delta;
      logic [31:0] run_ord;
      logic [11:0] recent_ord;
      logic [7:0]  code;
      logic        doc;
      bit          drained_once;

      fail_count   = 0;
      sent_items   = 0;
      calm_stretch = 1'b0;
      drained_once = 1'b0;
      recent_ord   = '0;
      run_ord      = '0;

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_DECODE;
      req_chan.doc_start  <= 1'b0;
      req_chan.code_byte  <= '0;
      req_chan.read_index <= '0;
      row_typed           <= 1'b0;
      row_tally           <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table; ready stays low through the clearing sweep
      for (int i = 0; i < $size(dir_rows); i++) begin
         send_item(dir_rows[i].op, dir_rows[i].doc_start, dir_rows[i].code_byte,
                   dir_rows[i].read_index, dir_rows[i].typed, dir_rows[i].tally);
      end

      // random part, grouped into documents, reads, noise and long codes
      while (sent_items < $size(dir_rows) + RANDOM_ITEMS) begin
         calm_stretch = ($urandom_range(0, 4) == 0);
         group = $urandom_range(0, 9);
         if (group < 6) begin
            // a well-formed document of delta-coded ordinals
            n_ords = $urandom_range(1, 8);
            for (int k = 0; k < n_ords; k++) begin
               pick = $urandom_range(0, 9);
               if (pick < 2) delta = '0;
               else if (pick < 8) delta = $urandom_range(1, 300);
               else if (pick < 9) delta = $urandom_range(0, ORD_SLOTS - 1);
               else delta = $urandom();
               run_ord = (k == 0) ? delta : run_ord + delta;
               if (run_ord < ORD_SLOTS) recent_ord = run_ord[11:0];
               n_grp = 1;
               while (n_grp < 5 && (delta >> (vdoh_pkg::DATA_BITS * n_grp)) != 0) n_grp++;
               // sometimes a redundant leading zero group
               if (n_grp < 5 && $urandom_range(0, 7) == 0) n_grp++;
               for (int g = n_grp; g > 0; g--) begin
                  code = {1'b0, 7'(delta >> (vdoh_pkg::DATA_BITS * (g - 1)))};
                  code[vdoh_pkg::MORE_BIT] = (g > 1);
                  send_item(OP_DECODE, (k == 0) && (g == n_grp), code,
                            12'($urandom_range(0, ORD_SLOTS - 1)), 1'b0, '0);
               end
            end
         end else if (group < 8) begin
            // reads, half of them on an ordinal just counted
            n_bytes = $urandom_range(1, 4);
            for (int k = 0; k < n_bytes; k++) begin
               send_item(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 1) ? recent_ord
                                              : 12'($urandom_range(0, ORD_SLOTS - 1)),
                         1'b0, '0);
            end
         end else if (group == 8) begin
            // noise: random bytes, random doc_start, the odd read
            n_bytes = $urandom_range(1, 6);
            for (int k = 0; k < n_bytes; k++) begin
               send_item(($urandom_range(0, 3) == 0) ? OP_READ : OP_DECODE,
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         12'($urandom_range(0, ORD_SLOTS - 1)), 1'b0, '0);
            end
         end else begin
            // long code that overflows 32 bits
            doc = 1'($urandom_range(0, 1));
            n_bytes = $urandom_range(4, 7);
            for (int k = 0; k < n_bytes; k++) begin
               send_item(OP_DECODE, doc && (k == 0), 8'($urandom_range(128, 255)),
                         12'($urandom_range(0, ORD_SLOTS - 1)), 1'b0, '0);
            end
            send_item(OP_DECODE, 1'b0, 8'($urandom_range(0, 127)),
                      12'($urandom_range(0, ORD_SLOTS - 1)), 1'b0, '0);
         end

         // once, hold off until every result has come back
         if (!drained_once && sent_items >= DRAIN_POINT) begin
            drained_once = 1'b1;
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_tallies.size() != 0);
         end
      end

      // drain, then a few quiet cycles to catch stray results
      calm_stretch = 1'b0;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_tallies.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_tallies.size() == 0) begin
         $display("** varint_delta_ordinal_histogram_unit: PASSED **");
      end else begin
         $display("** varint_delta_ordinal_histogram_unit: FAILED **");
      end
      $finish;
   end

endmodule
